@@ src/pwts_pkg.sv @@
// Shared types and constants of the world-to-screen projection block.
`timescale 1ns / 1ps
`default_nettype none

package pwts_pkg;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
   } rsp_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_CAM_POS_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAM_POS_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CAM_POS_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_DEG = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_DEG   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FOV_DEG   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_W  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_H  = 3'd7;

   localparam logic [15:0] FOV_RESET      = 16'd23040;
   localparam logic [12:0] SCREEN_W_RESET = 13'd1920;
   localparam logic [12:0] SCREEN_H_RESET = 13'd1080;

   // One full turn in Q8.8 degrees; 92160 = 2^11 * 45.
   localparam int DEG_TURN_Q8 = 92160;
   // Divide by 45 as multiply and shift; exact for operands below 2^20.
   localparam int RECIP_45    = 1491309;
   localparam int RECIP_SHIFT = 26;

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam longint      ONE_Q30    = 64'sd1073741824;
   localparam longint      ROT_LIMIT  = 64'sd8589934591;
   localparam longint      COT_CAP    = 64'sd16777215;
   localparam longint      DEPTH_MIN  = 64'sd65536;

   // Long division unit geometry.
   localparam int DIV_NUM_W = 63;
   localparam int DIV_DEN_W = 34;
   localparam int DIV_QUO_W = 47;

endpackage

`default_nettype wire

@@ src/pwts_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module pwts_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [pwts_pkg::DIV_NUM_W-1:0]  in_num,
   input  logic [pwts_pkg::DIV_DEN_W-1:0]  in_den,
   input  logic                            in_neg,
   output logic                            out_valid,
   output logic [pwts_pkg::DIV_QUO_W-1:0]  out_quo,
   output logic                            out_neg
);
   import pwts_pkg::*;

   localparam int STEPS = DIV_QUO_W;

   logic [DIV_DEN_W-1:0] rem_ff  [STEPS+1];
   logic [DIV_QUO_W-1:0] low_ff  [STEPS+1];
   logic [DIV_QUO_W-1:0] quo_ff  [STEPS+1];
   logic [DIV_DEN_W-1:0] den_ff  [STEPS+1];
   logic [STEPS:0]       neg_ff;
   logic [STEPS:0]       vld_ff;

   logic [DIV_DEN_W-1:0] rem_in  [STEPS];
   logic [DIV_QUO_W-1:0] quo_in  [STEPS];
   logic [DIV_DEN_W:0]   trial   [STEPS];
   logic [DIV_DEN_W:0]   diff    [STEPS];

   // Shift the next numerator bit into the partial remainder, subtract if it fits.
   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         trial[k] = {rem_ff[k], low_ff[k][DIV_QUO_W-1]};
         diff[k]  = trial[k] - {1'b0, den_ff[k]};
         if (trial[k] >= {1'b0, den_ff[k]}) begin
            rem_in[k] = diff[k][DIV_DEN_W-1:0];
            quo_in[k] = {quo_ff[k][DIV_QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][DIV_DEN_W-1:0];
            quo_in[k] = {quo_ff[k][DIV_QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= DIV_DEN_W'(in_num[DIV_NUM_W-1:DIV_QUO_W]);
      low_ff[0] <= in_num[DIV_QUO_W-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= in_den;
      for (int k = 0; k < STEPS; k++) begin
         rem_ff[k+1] <= rem_in[k];
         low_ff[k+1] <= {low_ff[k][DIV_QUO_W-2:0], 1'b0};
         quo_ff[k+1] <= quo_in[k];
         den_ff[k+1] <= den_ff[k];
      end
      neg_ff <= {neg_ff[STEPS-1:0], in_neg};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STEPS-1:0], in_valid};
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign out_quo   = quo_ff[STEPS];
   assign out_neg   = neg_ff[STEPS];

endmodule

`default_nettype wire

@@ src/perspective_world_to_screen.sv @@
// Top level: camera-relative perspective projection of world points to screen pixels.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                          | Beat
// ----------+--------------------------------+-----------------------------------------
// request   | start, busy, req_data          | start high and busy low at a clock edge
// response  | rsp_valid, rsp_data            | rsp_valid high for one cycle, no backpressure
// registers | csr_we, csr_index, csr_wdata   | csr_we high at a clock edge
//
// One point enters per clock while busy is low; every beat passes through 13 front
// stages, 48 divider stages incl. its input register, and 4 back stages ending in the
// output register. The depth is set by the 47-bit long division of the perspective
// divide, one quotient bit per stage.
// Reset is synchronous and clears control state only; busy is high during reset.
// The response side cannot stall, so nothing in the pipeline ever waits.
module perspective_world_to_screen #(
   parameter int TRIG_TABLE_ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pwts_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output pwts_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [pwts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pwts_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pwts_pkg::*;

   localparam int IDX_W = $clog2(TRIG_TABLE_ENTRIES);

   typedef logic signed [31:0] trig_tab_type [TRIG_TABLE_ENTRIES];
   typedef logic signed [24:0] cot_tab_type  [TRIG_TABLE_ENTRIES];

   // ------------------------------------------------------------------
   // Elaboration-time table builders
   // ------------------------------------------------------------------

   // Unsigned shift-and-subtract division, used only while building tables.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [31:0] frac_of(input int idx);
      logic [63:0] n;
      n = {32'(idx), 32'h0};
      return 32'(udiv64(n, 64'(TRIG_TABLE_ENTRIES)));
   endfunction

   // Fold to a quarter turn, convert to radians in Q30, Taylor series to x^15.
   function automatic logic signed [31:0] sin_of_frac(input logic [31:0] f);
      logic signed [33:0] g;
      logic               neg;
      logic [63:0]        mag;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] s;
      if (f < 32'h4000_0000) begin
         g = $signed({2'b00, f});
      end else if (f < 32'hC000_0000) begin
         g = 34'sh0_8000_0000 - $signed({2'b00, f});
      end else begin
         g = $signed({2'b00, f}) - 34'sh1_0000_0000;
      end
      neg = g[33];
      mag = neg ? 64'(-g) : 64'(g);
      x   = (mag * TWO_PI_Q30 + 64'h8000_0000) >> 32;
      x2  = (x * x + 64'h2000_0000) >> 30;
      s   = $signed(x);
      t   = x;
      for (int k = 1; k <= 7; k++) begin
         t = (t * x2 + 64'h2000_0000) >> 30;
         case (k)
            1:       t = udiv64(t, 64'd6);
            2:       t = udiv64(t, 64'd20);
            3:       t = udiv64(t, 64'd42);
            4:       t = udiv64(t, 64'd72);
            5:       t = udiv64(t, 64'd110);
            6:       t = udiv64(t, 64'd156);
            default: t = udiv64(t, 64'd210);
         endcase
         if (k % 2 == 1) begin
            s = s - $signed(t);
         end else begin
            s = s + $signed(t);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      if (s > ONE_Q30) begin
         s = ONE_Q30;
      end
      return neg ? 32'(-s) : 32'(s);
   endfunction

   function automatic trig_tab_type build_sin_tab();
      trig_tab_type tab;
      for (int i = 0; i < TRIG_TABLE_ENTRIES; i++) begin
         tab[i] = sin_of_frac(frac_of(i));
      end
      return tab;
   endfunction

   function automatic trig_tab_type build_cos_tab();
      trig_tab_type tab;
      for (int i = 0; i < TRIG_TABLE_ENTRIES; i++) begin
         tab[i] = sin_of_frac(frac_of(i) + 32'h4000_0000);
      end
      return tab;
   endfunction

   // Cotangent of the half field of view in Q16.16, rounded and capped.
   function automatic cot_tab_type build_cot_tab();
      cot_tab_type        tab;
      logic signed [63:0] sh;
      logic signed [63:0] ch;
      logic signed [63:0] n;
      logic signed [63:0] q;
      logic [63:0]        m;
      for (int i = 0; i < TRIG_TABLE_ENTRIES; i++) begin
         sh = 64'(sin_of_frac(frac_of(i)));
         ch = 64'(sin_of_frac(frac_of(i) + 32'h4000_0000));
         if (sh == 0) begin
            q = (ch >= 0) ? COT_CAP : -COT_CAP;
         end else begin
            if (sh < 0) begin
               sh = -sh;
               ch = -ch;
            end
            n = ch * 64'sd65536;
            m = (n < 0) ? $unsigned(-n) : $unsigned(n);
            q = $signed(udiv64(m + ($unsigned(sh) >> 1), $unsigned(sh)));
            if (n < 0) begin
               q = -q;
            end
            if (q > COT_CAP) begin
               q = COT_CAP;
            end
            if (q < -COT_CAP) begin
               q = -COT_CAP;
            end
         end
         tab[i] = 25'(q);
      end
      return tab;
   endfunction

   localparam trig_tab_type SIN_TAB = build_sin_tab();
   localparam trig_tab_type COS_TAB = build_cos_tab();
   localparam cot_tab_type  COT_TAB = build_cot_tab();

   function automatic logic signed [34:0] clamp_rot(input logic signed [37:0] v);
      if (v > 38'(ROT_LIMIT)) begin
         return 35'(ROT_LIMIT);
      end
      if (v < -38'(ROT_LIMIT)) begin
         return -35'(ROT_LIMIT);
      end
      return 35'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
      if (v > 58'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -58'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return 32'(v);
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [16:0]        pitch_ff, yaw_ff;
   logic [15:0]        fov_ff;
   logic [12:0]        scr_w_ff, scr_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
         pitch_ff <= '0;
         yaw_ff   <= '0;
         fov_ff   <= FOV_RESET;
         scr_w_ff <= SCREEN_W_RESET;
         scr_h_ff <= SCREEN_H_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_CAM_POS_X: cam_x_ff <= csr_wdata;
            REG_CAM_POS_Y: cam_y_ff <= csr_wdata;
            REG_CAM_POS_Z: cam_z_ff <= csr_wdata;
            REG_PITCH_DEG: pitch_ff <= csr_wdata[16:0];
            REG_YAW_DEG:   yaw_ff   <= csr_wdata[16:0];
            REG_FOV_DEG:   fov_ff   <= csr_wdata[15:0];
            REG_SCREEN_W:  scr_w_ff <= csr_wdata[12:0];
            REG_SCREEN_H:  scr_h_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Angle lookup chain. It runs freely off the registers. The user is to change
   // registers only with the pipeline empty (not enforced by the block), so stage k of
   // this chain is settled by the time stage k of the first point after a write reads it.
   // ------------------------------------------------------------------
   logic [17:0]        yaw_a, pitch_a, ry_full, rp_full;
   logic [16:0]        ry_ff, rp_ff, ry_in, rp_in;
   logic [31:0]        uy_tmp, up_tmp, uh_tmp;
   logic [19:0]        uy_ff, up_ff, uh_ff;
   logic [40:0]        iy_prod, ip_prod, ih_prod;
   logic [14:0]        iy_q, ip_q, ih_q;
   logic [IDX_W-1:0]   iy_ff, ip_ff, ih_ff, iy_in, ip_in, ih_in;
   logic signed [31:0] sy_ff, cy_ff, sp_ff, cp_ff;
   logic signed [24:0] cot_ff;

   always_comb begin
      // Wrap the angle into one turn; pitch is used negated.
      yaw_a   = {yaw_ff[16], yaw_ff};
      pitch_a = 18'(-$signed({pitch_ff[16], pitch_ff}));
      ry_full = yaw_a[17]   ? yaw_a   + 18'(DEG_TURN_Q8) : yaw_a;
      rp_full = pitch_a[17] ? pitch_a + 18'(DEG_TURN_Q8) : pitch_a;
      ry_in   = ry_full[16:0];
      rp_in   = rp_full[16:0];
      // Round to the nearest table step: the /2^11 part of /92160 here...
      uy_tmp  = 32'(ry_ff) * 32'(TRIG_TABLE_ENTRIES) + 32'(DEG_TURN_Q8 / 2);
      up_tmp  = 32'(rp_ff) * 32'(TRIG_TABLE_ENTRIES) + 32'(DEG_TURN_Q8 / 2);
      uh_tmp  = 32'(fov_ff) * 32'(TRIG_TABLE_ENTRIES) + 32'(DEG_TURN_Q8);
      // ...and the /45 part here, folding a full turn back to zero.
      iy_prod = 41'(uy_ff) * 41'(RECIP_45);
      ip_prod = 41'(up_ff) * 41'(RECIP_45);
      ih_prod = 41'(uh_ff) * 41'(RECIP_45);
      iy_q    = iy_prod[RECIP_SHIFT+14:RECIP_SHIFT];
      ip_q    = ip_prod[RECIP_SHIFT+14:RECIP_SHIFT];
      ih_q    = ih_prod[RECIP_SHIFT+14:RECIP_SHIFT];
      iy_in   = (iy_q >= 15'(TRIG_TABLE_ENTRIES)) ?
                IDX_W'(iy_q - 15'(TRIG_TABLE_ENTRIES)) : IDX_W'(iy_q);
      ip_in   = (ip_q >= 15'(TRIG_TABLE_ENTRIES)) ?
                IDX_W'(ip_q - 15'(TRIG_TABLE_ENTRIES)) : IDX_W'(ip_q);
      ih_in   = IDX_W'(ih_q);
   end

   always_ff @(posedge clock) begin
      ry_ff  <= ry_in;
      rp_ff  <= rp_in;
      uy_ff  <= uy_tmp[30:11];
      up_ff  <= up_tmp[30:11];
      uh_ff  <= uh_tmp[31:12];
      iy_ff  <= iy_in;
      ip_ff  <= ip_in;
      ih_ff  <= ih_in;
      sy_ff  <= SIN_TAB[iy_ff];
      sp_ff  <= SIN_TAB[ip_ff];
      cy_ff  <= COS_TAB[iy_ff];
      cp_ff  <= COS_TAB[ip_ff];
      cot_ff <= COT_TAB[ih_ff];
   end

   // ------------------------------------------------------------------
   // Point pipeline
   // ------------------------------------------------------------------
   logic               take;
   logic [12:0]        vld_ff;

   logic signed [32:0] dx_ff [4];
   logic signed [32:0] dz_ff [4];
   logic signed [32:0] dy_ff [7];

   logic signed [64:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [64:0] pa_rnd, pb_rnd, pc_rnd, pd_rnd;
   logic signed [34:0] ra_ff, rb_ff, rc_ff, rd_ff;
   logic signed [34:0] x1_ff, z1_ff, x1_in, z1_in;
   logic signed [34:0] x1d_ff [3];

   logic signed [66:0] qa_ff, qb_ff, qc_ff, qd_ff;
   logic signed [66:0] qa_rnd, qb_rnd, qc_rnd, qd_rnd;
   logic signed [36:0] sa_ff, sb_ff, sc_ff, sd_ff;
   logic signed [34:0] y2_ff, y2_in, z2_rot;
   logic [33:0]        z2_ff, z2_in;
   logic [33:0]        z2d_ff [2];

   logic signed [59:0] nx_ff, ny_ff;
   logic [58:0]        mx_ff, my_ff;
   logic               negx_ff, negy_ff;
   logic [DIV_NUM_W-1:0] numx_ff, numy_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic               negx13_ff, negy13_ff;

   assign busy = reset;
   assign take = start && !busy;

   always_comb begin
      pa_rnd = pa_ff + 65'sd536870912;
      pb_rnd = pb_ff + 65'sd536870912;
      pc_rnd = pc_ff + 65'sd536870912;
      pd_rnd = pd_ff + 65'sd536870912;
      x1_in  = clamp_rot(38'(ra_ff) - 38'(rb_ff));
      z1_in  = clamp_rot(38'(rc_ff) + 38'(rd_ff));
      qa_rnd = qa_ff + 67'sd536870912;
      qb_rnd = qb_ff + 67'sd536870912;
      qc_rnd = qc_ff + 67'sd536870912;
      qd_rnd = qd_ff + 67'sd536870912;
      y2_in  = clamp_rot(38'(sa_ff) - 38'(sb_ff));
      z2_rot = clamp_rot(38'(sc_ff) + 38'(sd_ff));
      // Depths under 1.0, also at or behind the camera plane, are pulled to 1.0.
      z2_in  = (z2_rot < 35'(DEPTH_MIN)) ? 34'(DEPTH_MIN) : 34'(z2_rot);
   end

   always_ff @(posedge clock) begin
      // S1: camera-relative delta
      dx_ff[0] <= 33'(req_data.world_x) - 33'(cam_x_ff);
      dy_ff[0] <= 33'(req_data.world_y) - 33'(cam_y_ff);
      dz_ff[0] <= 33'(req_data.world_z) - 33'(cam_z_ff);
      for (int k = 1; k < 4; k++) begin
         dx_ff[k] <= dx_ff[k-1];
         dz_ff[k] <= dz_ff[k-1];
      end
      for (int k = 1; k < 7; k++) begin
         dy_ff[k] <= dy_ff[k-1];
      end
      // S5: yaw products
      pa_ff <= 65'(dx_ff[3]) * 65'(cy_ff);
      pb_ff <= 65'(dz_ff[3]) * 65'(sy_ff);
      pc_ff <= 65'(dx_ff[3]) * 65'(sy_ff);
      pd_ff <= 65'(dz_ff[3]) * 65'(cy_ff);
      // S6: round to Q16.16
      ra_ff <= pa_rnd[64:30];
      rb_ff <= pb_rnd[64:30];
      rc_ff <= pc_rnd[64:30];
      rd_ff <= pd_rnd[64:30];
      // S7: yaw sums
      x1_ff <= x1_in;
      z1_ff <= z1_in;
      // S8: pitch products
      qa_ff <= 67'(dy_ff[6]) * 67'(cp_ff);
      qb_ff <= 67'(z1_ff) * 67'(sp_ff);
      qc_ff <= 67'(dy_ff[6]) * 67'(sp_ff);
      qd_ff <= 67'(z1_ff) * 67'(cp_ff);
      x1d_ff[0] <= x1_ff;
      x1d_ff[1] <= x1d_ff[0];
      x1d_ff[2] <= x1d_ff[1];
      // S9: round
      sa_ff <= qa_rnd[66:30];
      sb_ff <= qb_rnd[66:30];
      sc_ff <= qc_rnd[66:30];
      sd_ff <= qd_rnd[66:30];
      // S10: pitch sums and depth floor
      y2_ff <= y2_in;
      z2_ff <= z2_in;
      // S11: scale by the cotangent
      nx_ff     <= 60'(x1d_ff[2]) * 60'(cot_ff);
      ny_ff     <= 60'(y2_ff) * 60'(cot_ff);
      z2d_ff[0] <= z2_ff;
      // S12: sign and magnitude
      negx_ff   <= nx_ff[59];
      negy_ff   <= ny_ff[59];
      mx_ff     <= nx_ff[59] ? 59'(-nx_ff) : 59'(nx_ff);
      my_ff     <= ny_ff[59] ? 59'(-ny_ff) : 59'(ny_ff);
      z2d_ff[1] <= z2d_ff[0];
      // S13: times 16 plus half the divisor, so the divide rounds
      numx_ff   <= 63'({mx_ff, 4'b0}) + 63'(z2d_ff[1] >> 1);
      numy_ff   <= 63'({my_ff, 4'b0}) + 63'(z2d_ff[1] >> 1);
      den_ff    <= z2d_ff[1];
      negx13_ff <= negx_ff;
      negy13_ff <= negy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[11:0], take};
      end
   end

   // ------------------------------------------------------------------
   // Perspective divide, one lane per coordinate
   // ------------------------------------------------------------------
   logic                 divx_vld, divy_vld;
   logic [DIV_QUO_W-1:0] quox, quoy;
   logic                 negx_d, negy_d;

   pwts_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[12]),
      .in_num    (numx_ff),
      .in_den    (den_ff),
      .in_neg    (negx13_ff),
      .out_valid (divx_vld),
      .out_quo   (quox),
      .out_neg   (negx_d)
   );

   pwts_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[12]),
      .in_num    (numy_ff),
      .in_den    (den_ff),
      .in_neg    (negy13_ff),
      .out_valid (divy_vld),
      .out_quo   (quoy),
      .out_neg   (negy_d)
   );

   // ------------------------------------------------------------------
   // Back end: apply sign, scale by the width, offset from the centre
   // ------------------------------------------------------------------
   logic [3:0]         dv_ff;
   logic signed [47:0] qsx_ff, qsy_ff;
   logic signed [60:0] px_ff, py_ff, px_rnd, py_rnd;
   logic signed [55:0] offx_ff, offy_ff;
   logic signed [57:0] resx, resy;
   pwts_pkg::rsp_type  rsp_ff;

   always_comb begin
      px_rnd = px_ff + 61'sd16;
      py_rnd = py_ff + 61'sd16;
      resx   = $signed(58'({scr_w_ff, 15'b0})) - 58'(offx_ff);
      resy   = $signed(58'({scr_h_ff, 15'b0})) - 58'(offy_ff);
   end

   always_ff @(posedge clock) begin
      qsx_ff  <= negx_d ? -$signed(48'(quox)) : $signed(48'(quox));
      qsy_ff  <= negy_d ? -$signed(48'(quoy)) : $signed(48'(quoy));
      px_ff   <= 61'(qsx_ff) * 61'($signed({1'b0, scr_w_ff}));
      py_ff   <= 61'(qsy_ff) * 61'($signed({1'b0, scr_w_ff}));
      offx_ff <= px_rnd[60:5];
      offy_ff <= py_rnd[60:5];
      rsp_ff.screen_x <= sat32(resx);
      rsp_ff.screen_y <= sat32(resy);
   end

   // Both lanes run in lockstep; advance the beat when both report it.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else begin
         dv_ff <= {dv_ff[2:0], divx_vld & divy_vld};
      end
   end

   assign rsp_valid = dv_ff[3];
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the world-to-screen perspective projection block.
`timescale 1ns / 1ps

module tb;
   import pwts_pkg::*;

   localparam int TAB_N    = 1024;
   // Pipeline latency plus margin.
   localparam int PIPE_LAT = 80;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   perspective_world_to_screen #(.TRIG_TABLE_ENTRIES(TAB_N)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Camera settings as the predictor sees them.
   longint cam_x, cam_y, cam_z, pitch_q8, yaw_q8, fov_q8, scr_w, scr_h;

   rsp_type pixel_q[$];      // projected pixels waiting on the DUT
   bit      pinned_q[$];     // directed rows: 1 = use typed pixel below
   rsp_type pinned_px_q[$];
   int      mismatches;
   int      beats_in, beats_out;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timeout with %0d beats outstanding", pixel_q.size());
      $display("perspective_world_to_screen verification failed");
      $finish;
   end

   // ---------------- projection predictor ----------------

   function automatic longint sine_of_turn(logic [31:0] f);
      longint g, s;
      bit neg;
      longint unsigned mag, x, x2, t;
      if (f < 32'h4000_0000) g = longint'(f);
      else if (f < 32'hC000_0000) g = 64'sh8000_0000 - longint'(f);
      else g = longint'(f) - 64'sh1_0000_0000;
      neg = g < 0;
      mag = neg ? -g : g;
      x   = (mag * TWO_PI_Q30 + 64'h8000_0000) >> 32;
      x2  = (x * x + (64'd1 << 29)) >> 30;
      s   = x;
      t   = x;
      for (int k = 1; k <= 7; k++) begin
         t = (t * x2 + (64'd1 << 29)) >> 30;
         t = t / ((2 * k) * (2 * k + 1));
         if (k % 2 == 1) s -= t; else s += t;
      end
      if (s < 0) s = 0;
      if (s > ONE_Q30) s = ONE_Q30;
      return neg ? -s : s;
   endfunction

   function automatic logic [31:0] turn_of_slot(longint unsigned idx);
      longint unsigned v;
      v = (idx << 32) / TAB_N;
      return v[31:0];
   endfunction

   function automatic longint slot_of_angle(longint a);
      longint r;
      r = a % DEG_TURN_Q8;
      if (r < 0) r += DEG_TURN_Q8;
      r = (r * TAB_N + DEG_TURN_Q8 / 2) / DEG_TURN_Q8;
      if (r >= TAB_N) r -= TAB_N;
      return r;
   endfunction

   function automatic longint slot_sin(longint i);
      return sine_of_turn(turn_of_slot(i));
   endfunction

   function automatic longint slot_cos(longint i);
      return sine_of_turn(turn_of_slot(i) + 32'h4000_0000);
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      return (a * b + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic longint clip_rot(longint v);
      if (v > ROT_LIMIT) return ROT_LIMIT;
      if (v < -ROT_LIMIT) return -ROT_LIMIT;
      return v;
   endfunction

   // Round half away from zero, positive divisor.
   function automatic longint div_round(longint n, longint d);
      longint m;
      m = n < 0 ? -n : n;
      m = (m + d / 2) / d;
      return n < 0 ? -m : m;
   endfunction

   function automatic longint pixel_offset(longint v, longint cot, longint z, longint w);
      longint q;
      q = div_round(v * cot * 16, z);
      return (q * w + 16) >>> 5;
   endfunction

   function automatic logic [31:0] sat_q16(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic rsp_type project_point(req_type p);
      longint dx, dy, dz, yi, pi, hi, sy, cy, sp, cp, x1, z1, y2, z2, sh, ch, cot;
      rsp_type r;
      dx = longint'(p.world_x) - cam_x;
      dy = longint'(p.world_y) - cam_y;
      dz = longint'(p.world_z) - cam_z;
      yi = slot_of_angle(yaw_q8);
      pi = slot_of_angle(-pitch_q8);
      sy = slot_sin(yi); cy = slot_cos(yi);
      sp = slot_sin(pi); cp = slot_cos(pi);
      x1 = clip_rot(mul_q30(dx, cy) - mul_q30(dz, sy));
      z1 = clip_rot(mul_q30(dx, sy) + mul_q30(dz, cy));
      y2 = clip_rot(mul_q30(dy, cp) - mul_q30(z1, sp));
      z2 = clip_rot(mul_q30(dy, sp) + mul_q30(z1, cp));
      if (z2 < DEPTH_MIN) z2 = DEPTH_MIN;
      hi = (fov_q8 * TAB_N + DEG_TURN_Q8) / (2 * DEG_TURN_Q8);
      if (hi >= TAB_N) hi = hi % TAB_N;
      sh = slot_sin(hi);
      ch = slot_cos(hi);
      if (sh == 0) begin
         cot = ch >= 0 ? COT_CAP : -COT_CAP;
      end else begin
         if (sh < 0) begin
            sh = -sh;
            ch = -ch;
         end
         cot = div_round(ch * 65536, sh);
         if (cot > COT_CAP) cot = COT_CAP;
         if (cot < -COT_CAP) cot = -COT_CAP;
      end
      r.screen_x = sat_q16(scr_w * 32768 - pixel_offset(x1, cot, z2, scr_w));
      r.screen_y = sat_q16(scr_h * 32768 - pixel_offset(y2, cot, z2, scr_w));
      return r;
   endfunction

   // ---------------- accept and check ----------------

   // Sample at the edge: start and busy still hold their pre-edge values here.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         bit      pin;
         rsp_type typed;
         beats_in++;
         pin   = 1'b0;
         typed = '0;
         if (pinned_q.size() > 0) begin
            pin   = pinned_q.pop_front();
            typed = pinned_px_q.pop_front();
         end
         if (pin)
            pixel_q.push_back(typed);
         else
            pixel_q.push_back(project_point(req_data));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         rsp_type want;
         beats_out++;
         if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat x=%0d y=%0d", rsp_data.screen_x, rsp_data.screen_y);
         end else begin
            want = pixel_q.pop_front();
            if (want.screen_x !== rsp_data.screen_x || want.screen_y !== rsp_data.screen_y) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: expected x=%0d y=%0d, got x=%0d y=%0d", beats_out,
                           want.screen_x, want.screen_y, rsp_data.screen_x, rsp_data.screen_y);
            end
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   // Hold start until the beat is taken; busy only moves at rising edges.
   task automatic send_point(req_type p, bit pin, rsp_type px);
      int gap;
      pinned_q.push_back(pin);
      pinned_px_q.push_back(px);
      start    <= 1'b1;
      req_data <= p;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      gap = $urandom_range(0, 99);
      if (gap >= 60) begin
         start <= 1'b0;
         repeat (gap < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clock);
      end
   endtask

   task automatic send_free(req_type p, bit no_gaps);
      pinned_q.push_back(1'b0);
      pinned_px_q.push_back('0);
      start    <= 1'b1;
      req_data <= p;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      if (!no_gaps && $urandom_range(0, 99) >= 60) begin
         start <= 1'b0;
         repeat ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   // Drain the pipeline before touching camera settings.
   task automatic drain();
      start <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_CAM_POS_X: cam_x    = longint'(signed'(val));
         REG_CAM_POS_Y: cam_y    = longint'(signed'(val));
         REG_CAM_POS_Z: cam_z    = longint'(signed'(val));
         REG_PITCH_DEG: pitch_q8 = longint'(signed'(val[16:0]));
         REG_YAW_DEG:   yaw_q8   = longint'(signed'(val[16:0]));
         REG_FOV_DEG:   fov_q8   = longint'(val[15:0]);
         REG_SCREEN_W:  scr_w    = longint'(val[12:0]);
         default:       scr_h    = longint'(val[12:0]);
      endcase
   endtask

   task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] pt, logic [31:0] yw, logic [31:0] fv,
                             logic [31:0] w, logic [31:0] h);
      write_reg(REG_CAM_POS_X, cx);
      write_reg(REG_CAM_POS_Y, cy);
      write_reg(REG_CAM_POS_Z, cz);
      write_reg(REG_PITCH_DEG, pt);
      write_reg(REG_YAW_DEG, yw);
      write_reg(REG_FOV_DEG, fv);
      write_reg(REG_SCREEN_W, w);
      write_reg(REG_SCREEN_H, h);
   endtask

   // Mostly points in a box around the camera, some anywhere, some at the rails.
   function automatic req_type random_point();
      req_type p;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         p.world_x = 32'(cam_x + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
         p.world_y = 32'(cam_y + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
         p.world_z = 32'(cam_z + $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0010_0000);
      end else if (pick < 9) begin
         p.world_x = $urandom();
         p.world_y = $urandom();
         p.world_z = $urandom();
      end else begin
         p.world_x = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         p.world_y = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         p.world_z = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      return p;
   endfunction

   // ---------------- directed table ----------------

   typedef struct {
      logic [31:0] wx, wy, wz;
      bit          pin;
      logic [31:0] ex, ey;
   } dir_row_type;

   // Screen centre at reset size: 960 and 540 pixels in Q16.16.
   localparam logic [31:0] CX0 = 32'd62914560;
   localparam logic [31:0] CY0 = 32'd35389440;

   dir_row_type dir_tab[20];

   initial begin
      // Points on the view axis land on the centre whatever their depth.
      dir_tab[0]  = '{32'h0, 32'h0, 32'h0, 1, CX0, CY0};
      dir_tab[1]  = '{32'h0, 32'h0, 32'h7FFF_FFFF, 1, CX0, CY0};
      dir_tab[2]  = '{32'h0, 32'h0, 32'h8000_0000, 1, CX0, CY0};   // behind the camera
      dir_tab[3]  = '{32'h0, 32'h0, 32'h0001_0000, 1, CX0, CY0};
      dir_tab[4]  = '{32'h0, 32'h0, 32'h0000_FFFF, 1, CX0, CY0};   // just under unit depth
      dir_tab[5]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0};
      dir_tab[6]  = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0};
      dir_tab[7]  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0, 0};   // saturate
      dir_tab[8]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0, 0, 0};
      dir_tab[9]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0};
      dir_tab[10] = '{32'h0001_0000, 32'h0001_0000, 32'h000A_0000, 0, 0, 0};
      dir_tab[11] = '{32'hFFFF_0000, 32'hFFFF_0000, 32'h000A_0000, 0, 0, 0};
      dir_tab[12] = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0002_0000, 0, 0, 0};
      dir_tab[13] = '{32'h0064_0000, 32'h0000_0000, 32'h0064_0000, 0, 0, 0};
      dir_tab[14] = '{32'h0000_0000, 32'h0064_0000, 32'h0064_0000, 0, 0, 0};
      dir_tab[15] = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0};
      dir_tab[16] = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA, 0, 0, 0};
      dir_tab[17] = '{32'h0010_0000, 32'h0010_0000, 32'h0000_8000, 0, 0, 0};
      dir_tab[18] = '{32'h7FFF_0000, 32'h0, 32'h0000_0001, 0, 0, 0};
      dir_tab[19] = '{32'h0, 32'h8000_0001, 32'h0300_0000, 0, 0, 0};
   end

   // ---------------- main sequence ----------------

   initial begin
      req_type p;
      rsp_type px;
      bit      no_gaps;
      start = 1'b0; req_data = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      cam_x = 0; cam_y = 0; cam_z = 0; pitch_q8 = 0; yaw_q8 = 0;
      fov_q8 = FOV_RESET; scr_w = SCREEN_W_RESET; scr_h = SCREEN_H_RESET;
      mismatches = 0; beats_in = 0; beats_out = 0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under the reset camera.
      foreach (dir_tab[i]) begin
         p.world_x = dir_tab[i].wx;
         p.world_y = dir_tab[i].wy;
         p.world_z = dir_tab[i].wz;
         px.screen_x = dir_tab[i].ex;
         px.screen_y = dir_tab[i].ey;
         send_point(p, dir_tab[i].pin, px);
      end

      // Camera phases: extremes first, then random settings.
      for (int ph = 0; ph < 14; ph++) begin
         drain();
         case (ph)
            0: set_camera(0, 0, 0, 32'd46080, 32'd46080, 32'd256, 32'd4096, 32'd4096);
            1: set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          -32'sd46080, -32'sd46080, 32'd45824, 32'd1, 32'd1);
            2: set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'd11520, 32'd23040, 32'd0, 32'd0, 32'd0);   // zero half-fov sine
            3: set_camera(32'h0010_0000, 0, 32'hFFF0_0000,
                          0, 32'd2560, 32'hFFFF, 32'h1FFF, 32'h1FFF);   // half fov past ninety
            4: set_camera(0, 0, 0, 32'h1FFFF, 32'h10000, 32'd46080, 32'd640, 32'd480);
            5: set_camera(0, 0, 0, 32'd23040, 32'd0, 32'd23040, 32'd1920, 32'd1080);
            default: set_camera($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom_range(0, 3) == 0 ? $urandom() :
                                    $urandom_range(256, 45824),
                                 $urandom_range(0, 3) == 0 ? $urandom() :
                                    $urandom_range(1, 4096),
                                 $urandom_range(0, 3) == 0 ? $urandom() :
                                    $urandom_range(1, 4096));
         endcase
         // Some phases run back to back with no gaps at all.
         no_gaps = (ph % 4 == 3);
         repeat (80) send_free(random_point(), no_gaps);
      end

      drain();
      $display("covered %0d points over 15 camera settings, %0d projected pixels checked",
               beats_in, beats_out);
      $display("settings included angle and screen extremes, zero and obtuse fields of view");
      if (mismatches == 0 && pixel_q.size() == 0) begin
         $display("perspective_world_to_screen verification clean");
      end else begin
         $display("%0d mismatches, %0d pixels never arrived", mismatches, pixel_q.size());
         $display("perspective_world_to_screen verification failed");
      end
      $finish;
   end

endmodule
